// ===== src/even_palindrome_mode_char_unit_defines.svh =====
// Assertion macros shared by the checker of the palindrome / mode-byte unit
`ifndef EVEN_PALINDROME_MODE_CHAR_UNIT_DEFINES_SVH
`define EVEN_PALINDROME_MODE_CHAR_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define EPMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define EPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/epmc_pkg.sv =====
// Shared types and constants for the palindrome / mode-byte unit
package epmc_pkg;

  localparam int unsigned NUM_VALS = 256;
  localparam logic [7:0]  VAL_LAST = 8'hFF;
  localparam logic [7:0]  CNT_MAX  = 8'hFF;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_HWR   = 7'b0000100,
    ST_PAL   = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_SFIN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [7:0] raddr;
    logic [7:0] waddr;
    logic       inc;
    logic       zero;
    logic       scan;
    logic       scan_start;
  } hist_ctl_t;

endpackage

// ===== src/epmc_hist.sv =====
// Byte-value histogram: saturating increment, clearing scan and mode tracking
module epmc_hist import epmc_pkg::*; (
  input  logic       clk,
  input  hist_ctl_t  ctl,
  output logic [7:0] mode_char
);

  logic [7:0] cnt_mem [0:NUM_VALS-1];
  logic [7:0] rdata_r;
  logic [7:0] best_r;
  logic [7:0] best_cnt_r;
  logic [7:0] inc_val;

  assign inc_val = (rdata_r == CNT_MAX) ? CNT_MAX : rdata_r + 8'd1;

  always_ff @(posedge clk) begin
    if (ctl.inc) begin
      cnt_mem[ctl.waddr] <= inc_val;
    end else if (ctl.zero) begin
      cnt_mem[ctl.waddr] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= cnt_mem[ctl.raddr];
  end

  // strict compare keeps the smaller byte value on a tie
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      best_r     <= '0;
      best_cnt_r <= '0;
    end else if (ctl.scan && (rdata_r > best_cnt_r)) begin
      best_r     <= ctl.waddr;
      best_cnt_r <= rdata_r;
    end
  end

  assign mode_char = best_r;

endmodule

// ===== src/even_palindrome_mode_char_unit.sv =====
// Top level: even-length palindrome test with most frequent byte per string
//
//  channel | ports                                   | beat
//  --------+-----------------------------------------+------------------------------
//  in      | in_valid in_ready in_char in_last_char  | one byte, flag on final byte
//  out     | out_valid out_ready out_qualifies        | one result per string
//          | out_mode_char out_str_len out_too_long  |
//
// Each byte: histogram read in ST_IDLE, then write back in ST_HWR (one read and one write port).
// At string end: a mirror compare on the buffer's two read ports, a pass scanning and
// clearing the 256-entry histogram, then the result is loaded.
// After reset a clearing pass runs over the 256-entry histogram; in_ready is low.
// A finished result waits in the output register while the next string loads.
module even_palindrome_mode_char_unit import epmc_pkg::*; #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_qualifies,
  output logic [7:0] out_mode_char,
  output logic [7:0] out_str_len,
  output logic       out_too_long
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  state_t          state_r, state_nxt;
  logic [LW-1:0]   len_r;
  logic            ovf_r;
  logic [7:0]      byte_r;
  logic            stored_r;
  logic            last_r;
  logic [AW-1:0]   idx_r;
  logic [7:0]      cnt_r;
  logic [7:0]      ra_r;
  logic            rv_r;
  logic            cmp_vld_r;
  logic            mism_r;
  logic [7:0]      b0_r, b1_r;
  logic [7:0]      cbuf_mem [0:MAX_LEN-1];
  logic            out_valid_r;
  logic            out_qualifies_r;
  logic [7:0]      out_mode_char_r;
  logic [7:0]      out_str_len_r;
  logic            out_too_long_r;

  logic            accept;
  logic            room;
  logic [LW-1:0]   half;
  logic            pal_more;
  logic [LW-1:0]   jdx;
  logic            out_free;
  logic [7:0]      mode_char;
  hist_ctl_t       hctl;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign room     = (len_r < LW'(MAX_LEN));
  assign half     = len_r >> 1;
  assign pal_more = (LW'(idx_r) < half);
  assign jdx      = len_r - LW'(1) - LW'(idx_r);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (cnt_r == VAL_LAST) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_HWR;
      ST_HWR:   state_nxt = last_r ? ST_PAL : ST_IDLE;
      ST_PAL:   if (!pal_more) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == VAL_LAST) state_nxt = ST_SFIN;
      ST_SFIN:  state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    hctl.raddr      = (state_r == ST_SCAN) ? cnt_r : in_char;
    hctl.inc        = (state_r == ST_HWR) && stored_r;
    hctl.zero       = (state_r == ST_CLEAR) || rv_r;
    hctl.scan       = rv_r;
    hctl.scan_start = (state_r == ST_PAL) && !pal_more;
    if (state_r == ST_CLEAR) begin
      hctl.waddr = cnt_r;
    end else if (rv_r) begin
      hctl.waddr = ra_r;
    end else begin
      hctl.waddr = byte_r;
    end
  end

  epmc_hist u_hist (
    .clk       (clk),
    .ctl       (hctl),
    .mode_char (mode_char)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      rv_r        <= 1'b0;
      cmp_vld_r   <= 1'b0;
      mism_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rv_r      <= (state_r == ST_SCAN);
      cmp_vld_r <= (state_r == ST_PAL) && pal_more;

      if ((state_r == ST_CLEAR) || (state_r == ST_SCAN)) begin
        cnt_r <= cnt_r + 8'd1;
      end else if ((state_r == ST_PAL) && !pal_more) begin
        cnt_r <= '0;
      end

      if (accept) begin
        if (room) begin
          len_r <= len_r + LW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end else if ((state_r == ST_DONE) && out_free) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end

      if ((state_r == ST_HWR) && last_r) begin
        idx_r  <= '0;
        mism_r <= 1'b0;
      end else begin
        if ((state_r == ST_PAL) && pal_more) begin
          idx_r <= idx_r + AW'(1);
        end
        if (cmp_vld_r && (b0_r != b1_r)) begin
          mism_r <= 1'b1;
        end
      end

      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_r <= cnt_r;
    if (accept) begin
      byte_r   <= in_char;
      stored_r <= room;
      last_r   <= in_last_char;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_qualifies_r <= !ovf_r && !len_r[0] && !mism_r;
      out_mode_char_r <= mode_char;
      out_str_len_r   <= 8'(len_r);
      out_too_long_r  <= ovf_r;
    end
  end

  // string buffer: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept && room) begin
      cbuf_mem[len_r[AW-1:0]] <= in_char;
    end
    b0_r <= cbuf_mem[idx_r];
    b1_r <= cbuf_mem[jdx[AW-1:0]];
  end

  assign out_valid     = out_valid_r;
  assign out_qualifies = out_qualifies_r;
  assign out_mode_char = out_mode_char_r;
  assign out_str_len   = out_str_len_r;
  assign out_too_long  = out_too_long_r;

endmodule

// ===== src/epmc_checker.sv =====
// Port-level checker for the palindrome / mode-byte unit, with its bind
`include "even_palindrome_mode_char_unit_defines.svh"

module epmc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_qualifies,
  input logic [7:0] out_mode_char,
  input logic [7:0] out_str_len,
  input logic       out_too_long
);

  `EPMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_qualifies) && $stable(out_mode_char) && $stable(out_str_len) && $stable(out_too_long), "result changed while stalled")
  `EPMC_ASSERT_NOW(a_long_not_qual, clk, rst_n, out_valid && out_too_long, !out_qualifies, "overlong string reported as qualifying")
  `EPMC_ASSERT_NOW(a_qual_even, clk, rst_n, out_valid && out_qualifies, !out_str_len[0], "qualifying string has odd length")
  `EPMC_ASSERT_NEXT(a_byte_two_cycles, clk, rst_n, in_valid && in_ready, !in_ready, "byte taken on consecutive cycles")

endmodule

bind even_palindrome_mode_char_unit epmc_checker u_epmc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_qualifies (out_qualifies),
  .out_mode_char (out_mode_char),
  .out_str_len   (out_str_len),
  .out_too_long  (out_too_long)
);
